/* hdl/ascalc_pkg.sv */
`default_nettype none
package ascalc_pkg;

    localparam int DefStackDepth  = 64;
    localparam int DefTableEntries = 256;

    typedef enum logic [2:0] {
        CMD_LOAD_CONST = 3'd0,
        CMD_LOAD_VAR   = 3'd1,
        CMD_STORE_VAR  = 3'd2,
        CMD_PUSH       = 3'd3,
        CMD_POP        = 3'd4,
        CMD_OPERATE    = 3'd5,
        CMD_CLEAR_STK  = 3'd6,
        CMD_CLEAR_ACC  = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_DIV = 2'd2,
        OP_MUL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // Integer part of a Q32.32 value, truncated toward zero (33 bits, signed).
    function automatic logic signed [32:0] trunc_int(input logic [63:0] q);
        logic [63:0] mag;
        logic [32:0] m;
        mag = q[63] ? (64'd0 - q) : q;
        m   = {1'b0, mag[63:32]};
        return q[63] ? $signed(33'd0 - m) : $signed(m);
    endfunction

    // Saturate to 32-bit signed range and return as Q32.32.
    function automatic logic [63:0] sat_to_q(input logic signed [66:0] r);
        logic [31:0] v;
        if (r > 67'sd2147483647) begin
            v = 32'h7fff_ffff;
        end else if (r < -67'sd2147483648) begin
            v = 32'h8000_0000;
        end else begin
            v = r[31:0];
        end
        return {v, 32'd0};
    endfunction

endpackage
`default_nettype wire

/* hdl/ascalc_div.sv */
`default_nettype none
// Restoring divider: one quotient bit a cycle on 33-bit magnitudes.
module ascalc_div
    import ascalc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [32:0] dividend,
    input  wire logic signed [32:0] divisor,
    output logic                    done,
    output logic signed [33:0]      quotient
);
    logic [32:0] num_reg, num_next;
    logic [32:0] den_reg;
    logic [33:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg;
    logic        busy_reg, neg_reg;
    logic [33:0] trial;

    always_comb begin
        trial    = {rem_reg[32:0], num_reg[32]} - {1'b0, den_reg};
        num_next = {num_reg[31:0], 1'b0};
        if (!trial[33]) begin
            rem_next    = trial;
            num_next[0] = 1'b1;
        end else begin
            rem_next = {rem_reg[32:0], num_reg[32]};
        end
    end

    always_ff @(posedge aclk) begin
        done <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd0;
            rem_reg  <= '0;
            num_reg  <= dividend[32] ? 33'(-dividend) : 33'(dividend);
            den_reg  <= divisor[32] ? 33'(-divisor) : 33'(divisor);
            neg_reg  <= dividend[32] ^ divisor[32];
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd32) begin
                busy_reg <= 1'b0;
                done     <= 1'b1;
            end
        end
    end

    assign quotient = neg_reg ? $signed(34'd0 - {1'b0, num_reg})
                              : $signed({1'b0, num_reg});
endmodule
`default_nettype wire

/* hdl/accumulator_stack_calculator_core.sv */
`default_nettype none
// Accumulator and operand-stack calculator with a variable table keyed by
// 64-bit names. One command is taken at a time, and the block is not ready
// again until its result word sits in the output register. Constant loads,
// pushes and clears go from dispatch to the output state; pops, adds and
// subtracts first read the stack top, and multiply then registers its product.
// Variable loads and stores scan the table entry by entry through its single
// read port. Divide uses a one-bit-a-cycle divider. A stalled output holds
// the block in its last state until the word is taken. No clearing pass is
// needed after reset.
module accumulator_stack_calculator_core
    import ascalc_pkg::*;
#(
    parameter int STACK_DEPTH   = DefStackDepth,
    parameter int TABLE_ENTRIES = DefTableEntries
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command[2:0], constant_value[66:3], variable_key[130:67],
    // operator_code[132:131], zero fill
    input  wire logic [135:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // accumulator_out[63:0], status[66:64], stack_depth[73:67],
    // created_variable[74], zero fill
    output logic [79:0]       m_tdata
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_SCAN_CHK, S_STK_RD, S_STK_USE,
        S_MUL, S_DIV, S_DONE
    } state_t;

    state_t      state_reg;
    cmd_t        cmd_reg;
    op_t         op_reg;
    logic [63:0] const_reg, key_reg, acc_reg;
    logic [CW-1:0] count_reg;
    logic [EW-1:0] used_reg, scan_reg;
    status_t     status_reg;
    logic        created_reg;

    logic [63:0] stack_mem [STACK_DEPTH];
    logic [63:0] name_mem  [TABLE_ENTRIES];
    logic [63:0] value_mem [TABLE_ENTRIES];
    logic [63:0] stk_rd_reg, name_rd_reg, value_rd_reg;

    logic               stk_we, tab_we, val_we;
    logic [SW-1:0]      stk_addr;
    logic [TW-1:0]      tab_addr;
    logic [63:0]        tab_name, tab_val;

    logic signed [32:0] opa_reg, opb_reg;
    logic signed [66:0] prod_reg;
    logic               div_start, div_done;
    logic signed [33:0] div_q;
    logic signed [32:0] div_a, div_b;

    always_ff @(posedge aclk) begin
        if (stk_we) stack_mem[stk_addr] <= acc_reg;
        stk_rd_reg <= stack_mem[stk_addr];
        if (tab_we) name_mem[tab_addr] <= tab_name;
        if (val_we) value_mem[tab_addr] <= tab_val;
        name_rd_reg  <= name_mem[tab_addr];
        value_rd_reg <= value_mem[tab_addr];
    end

    // The divider latches its operands on the start cycle, so they come straight
    // from the popped entry and the accumulator.
    assign div_a = trunc_int(stk_rd_reg);
    assign div_b = trunc_int(acc_reg);

    ascalc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    always_comb begin
        stk_we    = 1'b0;
        stk_addr  = (state_reg == S_DISPATCH && cmd_reg == CMD_PUSH)
                  ? count_reg[SW-1:0] : SW'(count_reg - CW'(1));
        tab_we    = 1'b0;
        val_we    = 1'b0;
        tab_addr  = scan_reg[TW-1:0];
        tab_name  = key_reg;
        tab_val   = acc_reg;
        div_start = 1'b0;
        case (state_reg)
            S_DISPATCH: begin
                if (cmd_reg == CMD_PUSH && count_reg < CW'(STACK_DEPTH)) stk_we = 1'b1;
            end
            S_SCAN_CHK: begin
                if (scan_reg < used_reg && name_rd_reg == key_reg) begin
                    if (cmd_reg == CMD_STORE_VAR) val_we = 1'b1;
                end else if (scan_reg >= used_reg && used_reg < EW'(TABLE_ENTRIES)) begin
                    tab_we = 1'b1;
                    val_we = 1'b1;
                    if (cmd_reg == CMD_LOAD_VAR) tab_val = '0;
                end
            end
            S_STK_USE: begin
                if (cmd_reg == CMD_OPERATE && op_reg == OP_DIV &&
                    trunc_int(acc_reg) != 33'sd0) div_start = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            used_reg  <= '0;
            acc_reg   <= '0;
            s_tready  <= 1'b0;
            m_tvalid  <= 1'b0;
        end else begin
            if (m_tvalid && m_tready && state_reg != S_DONE) m_tvalid <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        s_tready    <= 1'b0;
                        cmd_reg     <= cmd_t'(s_tdata[2:0]);
                        const_reg   <= s_tdata[66:3];
                        key_reg     <= s_tdata[130:67];
                        op_reg      <= op_t'(s_tdata[132:131]);
                        status_reg  <= ST_OK;
                        created_reg <= 1'b0;
                        scan_reg    <= '0;
                        state_reg   <= S_DISPATCH;
                    end else begin
                        s_tready <= 1'b1;
                    end
                end
                S_DISPATCH: begin
                    state_reg <= S_DONE;
                    case (cmd_reg)
                        CMD_LOAD_CONST: acc_reg <= const_reg;
                        CMD_LOAD_VAR, CMD_STORE_VAR: state_reg <= S_SCAN;
                        CMD_PUSH: begin
                            if (count_reg < CW'(STACK_DEPTH)) count_reg <= count_reg + CW'(1);
                            else status_reg <= ST_OVERFLOW;
                        end
                        CMD_POP, CMD_OPERATE: begin
                            if (count_reg == '0) status_reg <= ST_UNDERFLOW;
                            else state_reg <= S_STK_RD;
                        end
                        CMD_CLEAR_STK: count_reg <= '0;
                        default: acc_reg <= '0;
                    endcase
                end
                S_SCAN: state_reg <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (scan_reg < used_reg && name_rd_reg == key_reg) begin
                        if (cmd_reg == CMD_LOAD_VAR) acc_reg <= value_rd_reg;
                        state_reg <= S_DONE;
                    end else if (scan_reg >= used_reg) begin
                        if (cmd_reg == CMD_LOAD_VAR) acc_reg <= '0;
                        if (used_reg < EW'(TABLE_ENTRIES)) begin
                            used_reg    <= used_reg + EW'(1);
                            created_reg <= 1'b1;
                        end else begin
                            status_reg <= ST_FULL;
                        end
                        state_reg <= S_DONE;
                    end else begin
                        scan_reg  <= scan_reg + EW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_STK_RD: state_reg <= S_STK_USE;
                S_STK_USE: begin
                    count_reg <= count_reg - CW'(1);
                    opa_reg   <= trunc_int(stk_rd_reg);
                    opb_reg   <= trunc_int(acc_reg);
                    state_reg <= S_DONE;
                    if (cmd_reg == CMD_POP) begin
                        acc_reg <= stk_rd_reg;
                    end else begin
                        case (op_reg)
                            OP_ADD: acc_reg <= sat_to_q(67'(trunc_int(stk_rd_reg))
                                                      + 67'(trunc_int(acc_reg)));
                            OP_SUB: acc_reg <= sat_to_q(67'(trunc_int(stk_rd_reg))
                                                      - 67'(trunc_int(acc_reg)));
                            OP_MUL: state_reg <= S_MUL;
                            default: begin
                                if (trunc_int(acc_reg) == 33'sd0) status_reg <= ST_DIVZERO;
                                else state_reg <= S_DIV;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    prod_reg  <= 67'(opa_reg) * 67'(opb_reg);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (op_reg == OP_MUL) begin
                        acc_reg   <= sat_to_q(prod_reg);
                        state_reg <= S_DONE;
                    end else if (div_done) begin
                        acc_reg   <= sat_to_q(67'(div_q));
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid || m_tready) begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= {5'd0, created_reg, 7'(count_reg),
                                      3'(status_reg), acc_reg};
                        state_reg <= S_IDLE;
                        s_tready  <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= EW'(TABLE_ENTRIES)) else $error("table count beyond size");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready while busy");
`endif
endmodule
`default_nettype wire

/* bench/accumulator_stack_calculator_checker.sv */
`timescale 1ns / 100ps
module accumulator_stack_calculator_checker
    import ascalc_pkg::*;
#(
    parameter int STACK_DEPTH   = DefStackDepth,
    parameter int TABLE_ENTRIES = DefTableEntries
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [135:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [79:0]  m_tdata,
    output int                fail_count,
    output int                pending_count
);

    typedef struct packed {
        logic       created;
        logic [6:0] depth;
        status_t    status;
        logic [63:0] acc;
    } calc_word_t;

    logic [63:0] stack_mem [STACK_DEPTH];
    int          stack_cnt;
    logic [63:0] acc;
    logic [63:0] var_names [TABLE_ENTRIES];
    logic [63:0] var_values [TABLE_ENTRIES];
    int          vars_used;
    calc_word_t  expected_words [$];

    assign pending_count = expected_words.size();

    function automatic logic signed [32:0] int_part(input logic [63:0] q);
        logic [63:0] mag;
        mag = q[63] ? -q : q;
        return q[63] ? -$signed({1'b0, mag[63:32]}) : $signed({1'b0, mag[63:32]});
    endfunction

    function automatic logic [63:0] clamp_q(input logic signed [66:0] r);
        if (r > 67'sd2147483647) begin
            return {32'h7fff_ffff, 32'd0};
        end else if (r < -67'sd2147483648) begin
            return {32'h8000_0000, 32'd0};
        end
        return {r[31:0], 32'd0};
    endfunction

    function automatic int lookup(input logic [63:0] key);
        for (int i = 0; i < vars_used; i++) begin
            if (var_names[i] == key) return i;
        end
        return -1;
    endfunction

    task automatic execute(input logic [135:0] d);
        cmd_t cmd;
        op_t op;
        logic [63:0] key;
        calc_word_t w;
        int idx;
        logic signed [66:0] a, b, r;
        cmd = cmd_t'(d[2:0]);
        key = d[130:67];
        op  = op_t'(d[132:131]);
        w.status  = ST_OK;
        w.created = 1'b0;
        case (cmd)
            CMD_LOAD_CONST: acc = d[66:3];
            CMD_LOAD_VAR: begin
                idx = lookup(key);
                if (idx >= 0) begin
                    acc = var_values[idx];
                end else begin
                    if (vars_used < TABLE_ENTRIES) begin
                        var_names[vars_used]  = key;
                        var_values[vars_used] = '0;
                        vars_used++;
                        w.created = 1'b1;
                    end else begin
                        w.status = ST_FULL;
                    end
                    acc = '0;
                end
            end
            CMD_STORE_VAR: begin
                idx = lookup(key);
                if (idx >= 0) begin
                    var_values[idx] = acc;
                end else if (vars_used < TABLE_ENTRIES) begin
                    var_names[vars_used]  = key;
                    var_values[vars_used] = acc;
                    vars_used++;
                    w.created = 1'b1;
                end else begin
                    w.status = ST_FULL;
                end
            end
            CMD_PUSH: begin
                if (stack_cnt >= STACK_DEPTH) begin
                    w.status = ST_OVERFLOW;
                end else begin
                    stack_mem[stack_cnt] = acc;
                    stack_cnt++;
                end
            end
            CMD_POP: begin
                if (stack_cnt == 0) begin
                    w.status = ST_UNDERFLOW;
                end else begin
                    stack_cnt--;
                    acc = stack_mem[stack_cnt];
                end
            end
            CMD_OPERATE: begin
                if (stack_cnt == 0) begin
                    w.status = ST_UNDERFLOW;
                end else begin
                    stack_cnt--;
                    a = int_part(stack_mem[stack_cnt]);
                    b = int_part(acc);
                    r = '0;
                    case (op)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        default: begin
                            if (b == 0) w.status = ST_DIVZERO;
                            else r = a / b;
                        end
                    endcase
                    if (w.status == ST_OK) acc = clamp_q(r);
                end
            end
            CMD_CLEAR_STK: stack_cnt = 0;
            default: acc = '0;
        endcase
        w.acc   = acc;
        w.depth = 7'(stack_cnt);
        expected_words.push_back(w);
    endtask

    always @(posedge aclk) begin
        calc_word_t got, want;
        if (!aresetn) begin
            stack_cnt  <= 0;
            acc        <= '0;
            vars_used  <= 0;
            fail_count <= 0;
            expected_words.delete();
        end else begin
            if (s_tvalid && s_tready) execute(s_tdata);
            if (m_tvalid && m_tready) begin
                got = calc_word_t'(m_tdata[74:0]);
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got.acc !== want.acc || got.status !== want.status ||
                        got.depth !== want.depth || got.created !== want.created ||
                        m_tdata[79:75] !== '0) begin
                        $display("%0t: expected acc %h st %0d depth %0d new %0b, actual acc %h st %0d depth %0d new %0b",
                                 $time, want.acc, want.status, want.depth, want.created,
                                 got.acc, got.status, got.depth, got.created);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* bench/tb_accumulator_stack_calculator_core.sv */
`timescale 1ns / 100ps
module tb_accumulator_stack_calculator_core
    import ascalc_pkg::*;
();

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    int           fail_count;
    int           pending_count;
    bit           stimulus_done = 1'b0;
    bit           fast_drain = 1'b0;
    logic [63:0]  var_pool [8];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    accumulator_stack_calculator_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    accumulator_stack_calculator_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Constants often hold small integers so that arithmetic stays interesting.
    function automatic logic [63:0] pick_value();
        logic signed [31:0] small_int;
        case ($urandom_range(0, 5))
            0: return rand64();
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'h8000_0000_0000_0000;
            3: return {32'h0, $urandom()};
            default: begin
                small_int = $signed($urandom_range(0, 200)) - 100;
                return {small_int, $urandom_range(0, 1) ? $urandom() : 32'd0};
            end
        endcase
    endfunction

    task automatic send(input cmd_t cmd, input logic [63:0] value,
                        input logic [63:0] key, input op_t op);
        int gap;
        gap = fast_drain ? 0 : $urandom_range(0, 8);
        repeat (gap) @(negedge aclk);
        s_tdata  <= {3'b0, op, key, value, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0) @(negedge aclk);
    endtask

    // Receiver: random stall per word, with stretches of no stalling.
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            stall = fast_drain ? 0 : $urandom_range(0, 8);
            m_tready <= 1'b0;
            repeat (stall) @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        op_t op;
        int kind;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed: underflows, extremes, every operator, divide by zero, saturation.
        send(CMD_POP, '0, '0, OP_ADD);
        send(CMD_OPERATE, '0, '0, OP_DIV);
        send(CMD_LOAD_CONST, 64'h7fff_ffff_ffff_ffff, '0, OP_ADD);
        send(CMD_PUSH, '0, '0, OP_ADD);
        send(CMD_PUSH, '0, '0, OP_ADD);
        send(CMD_OPERATE, '0, '0, OP_ADD);
        send(CMD_LOAD_CONST, 64'h8000_0000_0000_0000, '0, OP_ADD);
        send(CMD_PUSH, '0, '0, OP_ADD);
        send(CMD_LOAD_CONST, 64'hffff_ffff_0000_0000, '0, OP_ADD);
        send(CMD_OPERATE, '0, '0, OP_DIV);
        send(CMD_PUSH, '0, '0, OP_ADD);
        send(CMD_LOAD_CONST, 64'hffff_fffe_8000_0000, '0, OP_ADD);
        send(CMD_OPERATE, '0, '0, OP_MUL);
        send(CMD_PUSH, '0, '0, OP_ADD);
        send(CMD_LOAD_CONST, 64'h0000_0000_ffff_ffff, '0, OP_ADD);
        send(CMD_OPERATE, '0, '0, OP_DIV);
        send(CMD_PUSH, '0, '0, OP_ADD);
        send(CMD_OPERATE, '0, '0, OP_SUB);
        send(CMD_LOAD_VAR, '0, 64'hffff_ffff_ffff_ffff, OP_ADD);
        send(CMD_STORE_VAR, '0, '0, OP_ADD);
        send(CMD_CLEAR_ACC, '0, '0, OP_ADD);
        send(CMD_LOAD_VAR, '0, '0, OP_ADD);
        send(CMD_CLEAR_STK, '0, '0, OP_ADD);
        // Let the design catch up completely once before random traffic.
        drain();
        for (int i = 0; i < 8; i++) var_pool[i] = rand64();
        // Fill the stack to overflow.
        for (int i = 0; i < 66; i++) send(CMD_PUSH, '0, '0, OP_ADD);
        send(CMD_CLEAR_STK, '0, '0, OP_ADD);
        // Fill the variable table past full with fresh names.
        for (int i = 0; i < 260; i++) begin
            send($urandom_range(0, 1) ? CMD_STORE_VAR : CMD_LOAD_VAR, '0,
                 {i[15:0], 48'(rand64())}, OP_ADD);
        end
        // Random part: mostly meaningful expressions over a pool of eight names.
        for (int i = 0; i < 1100; i++) begin
            op = op_t'($urandom_range(0, 3));
            kind = $urandom_range(0, 19);
            if (kind < 5) send(CMD_LOAD_CONST, pick_value(), rand64(), op);
            else if (kind < 8) send(CMD_PUSH, rand64(), rand64(), op);
            else if (kind < 12) send(CMD_OPERATE, rand64(), rand64(), op);
            else if (kind < 14) send(CMD_LOAD_VAR, rand64(), var_pool[$urandom_range(0, 7)], op);
            else if (kind < 16) send(CMD_STORE_VAR, rand64(), var_pool[$urandom_range(0, 7)], op);
            else if (kind < 17) send(CMD_POP, rand64(), rand64(), op);
            else if (kind < 18) send(CMD_CLEAR_ACC, rand64(), rand64(), op);
            else if (kind < 19) send(CMD_LOAD_VAR, rand64(), rand64(), op);
            else send(CMD_CLEAR_STK, rand64(), rand64(), op);
            if (i == 500) fast_drain = 1'b1;
            if (i == 700) fast_drain = 1'b0;
        end
        drain();
        repeat (400) @(negedge aclk);
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done);
        if (fail_count == 0 && pending_count == 0) begin
            $display("accumulator_stack_calculator_core: match");
        end else begin
            $display("accumulator_stack_calculator_core: mismatch");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("accumulator_stack_calculator_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
hdl/ascalc_pkg.sv
hdl/ascalc_div.sv
hdl/accumulator_stack_calculator_core.sv
bench/accumulator_stack_calculator_checker.sv
bench/tb_accumulator_stack_calculator_core.sv
